// File: hdl/iau_pkg.sv
// ----------------------------------------------------------------------------
// iau_pkg: shared types, constants and helpers of the interval unit
// Item and result types, operation codes, divider step and saturation.
// ----------------------------------------------------------------------------
package iau_pkg;

   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_BITS    = WORD_BITS + FRAC_BITS;  // dividend magnitude width
   localparam int WIDE_BITS   = NUM_BITS + 2;           // unsaturated result width
   localparam int PROD_BITS   = 2 * WORD_BITS;
   localparam int DIV_LANES   = 5;                      // centre plus four endpoint pairs
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // request mode codes
   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_MID = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZDIV = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_MID
   } op_type;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [WIDE_BITS-1:0] wide_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;

   localparam prod_type FRAC_MASK  = (prod_type'(1) <<< FRAC_BITS) - prod_type'(1);
   localparam wide_type WORD_MAX_W = (wide_type'(1) <<< (WORD_BITS - 1)) - wide_type'(1);
   localparam wide_type WORD_MIN_W = -WORD_MAX_W - wide_type'(1);

   // classified item, bounds already in order
   typedef struct packed {
      op_type   op;
      logic     zdiv;
      word_type ac;
      word_type alo;
      word_type ahi;
      word_type bc;
      word_type blo;
      word_type bhi;
   } item_type;

   // one divider lane: partial remainder, dividend/quotient shift, divisor
   typedef struct packed {
      logic [WORD_BITS-1:0] rem;
      logic [NUM_BITS-1:0]  sh;
      logic [WORD_BITS-1:0] dvs;
      logic                 neg;
   } lane_type;

   typedef struct packed {
      wide_type c;
      wide_type lo;
      wide_type hi;
   } wres_type;

   typedef struct packed {
      word_type   c;
      word_type   lo;
      word_type   hi;
      logic [1:0] status;
   } res_type;

   // one restoring division step: one quotient bit
   function automatic lane_type div_step(lane_type l);
      lane_type           o;
      logic [WORD_BITS:0] t;
      logic               ge;
      t     = {l.rem, l.sh[NUM_BITS-1]};
      ge    = (t >= {1'b0, l.dvs});
      o     = l;
      o.rem = ge ? WORD_BITS'(t - {1'b0, l.dvs}) : WORD_BITS'(t);
      o.sh  = {l.sh[NUM_BITS-2:0], ge};
      return o;
   endfunction

   function automatic wide_type wmin(wide_type x, wide_type y);
      return (x < y) ? x : y;
   endfunction

   function automatic wide_type wmax(wide_type x, wide_type y);
      return (x > y) ? x : y;
   endfunction

   function automatic logic overflows(wide_type v);
      return (v > WORD_MAX_W) || (v < WORD_MIN_W);
   endfunction

   function automatic word_type saturate(wide_type v);
      word_type r;
      if (v > WORD_MAX_W) begin
         r = WORD_BITS'(WORD_MAX_W);
      end else if (v < WORD_MIN_W) begin
         r = WORD_BITS'(WORD_MIN_W);
      end else begin
         r = WORD_BITS'(v);
      end
      return r;
   endfunction

endpackage

// File: hdl/iau_front.sv
// ----------------------------------------------------------------------------
// iau_front: request classification
// Orders each pair of bounds, decodes the mode and flags a zero divisor.
// ----------------------------------------------------------------------------
module iau_front
   import iau_pkg::*;
(
   input  logic [2:0] mode,
   input  word_type   a_center,
   input  word_type   a_low,
   input  word_type   a_high,
   input  word_type   b_center,
   input  word_type   b_low,
   input  word_type   b_high,
   output item_type   item
);

   op_type op;

   // mode decoder
   always_comb begin
      unique case (mode)
         MODE_ADD: op = OP_ADD;
         MODE_SUB: op = OP_SUB;
         MODE_MUL: op = OP_MUL;
         MODE_DIV: op = OP_DIV;
         MODE_MID: op = OP_MID;
         default:  op = OP_NONE;
      endcase
   end

   // swap reversed bounds, flag a divisor range through zero or a zero divisor centre
   always_comb begin
      item.op  = op;
      item.ac  = a_center;
      item.bc  = b_center;
      item.alo = (a_low > a_high) ? a_high : a_low;
      item.ahi = (a_low > a_high) ? a_low  : a_high;
      item.blo = (b_low > b_high) ? b_high : b_low;
      item.bhi = (b_low > b_high) ? b_low  : b_high;
      item.zdiv = ((item.blo <= 0) && (item.bhi >= 0)) || (b_center == 0);
   end

endmodule

// File: hdl/iau_queue.sv
// ----------------------------------------------------------------------------
// iau_queue: short item queue between front and back
// Lets the request side keep accepting while the datapath is stalled.
// ----------------------------------------------------------------------------
module iau_queue
   import iau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wr_item,
   output logic     full,
   input  logic     pop,
   output item_type rd_item,
   output logic     empty
);

   item_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff,  count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// File: hdl/iau_back.sv
// ----------------------------------------------------------------------------
// iau_back: interval datapath
// Multiplies, adds and runs five pipelined dividers, then rounds outward,
// saturates and queues the result in a two-beat output queue.
// ----------------------------------------------------------------------------
module iau_back
   import iau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output word_type   rsp_res_center,
   output word_type   rsp_res_low,
   output word_type   rsp_res_high,
   output logic [1:0] rsp_status
);

   logic     en;
   logic     s0_valid_ff;
   item_type s0_item_ff;
   logic     s1_valid_ff;
   item_type s1_item_ff;
   prod_type s1_prod_ff [DIV_LANES];
   lane_type s1_lane_ff [DIV_LANES];
   prod_type prod_in    [DIV_LANES];
   lane_type lane_in    [DIV_LANES];
   wres_type pre_in;

   logic     d_valid_ff [NUM_BITS];
   op_type   d_op_ff    [NUM_BITS];
   logic     d_zdiv_ff  [NUM_BITS];
   wres_type d_pre_ff   [NUM_BITS];
   lane_type d_lane_ff  [NUM_BITS][DIV_LANES];

   wide_type fl [DIV_LANES];
   wide_type cl [DIV_LANES];
   wres_type e_res_in;
   logic     e_valid_ff;
   logic     e_zdiv_ff;
   wres_type e_res_ff;
   res_type  fin;

   res_type    oq_ff [2];
   logic       oq_wr_ff, oq_rd_ff;
   logic [1:0] oq_count_ff, oq_count_in;
   logic       oq_full, oq_push, oq_pop;

   // the whole pipe moves while the output queue has room
   assign en    = !oq_full;
   assign q_pop = en && !q_empty;

   // stage 0: operands from the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_item_ff <= q_item;
      end
   end

   // stage 1: products and divider set-up
   always_comb begin
      word_type xs [DIV_LANES];
      word_type ds [DIV_LANES];
      logic [WORD_BITS-1:0] xm, dm;
      xs[0] = s0_item_ff.ac;   ds[0] = s0_item_ff.bc;
      xs[1] = s0_item_ff.alo;  ds[1] = s0_item_ff.blo;
      xs[2] = s0_item_ff.alo;  ds[2] = s0_item_ff.bhi;
      xs[3] = s0_item_ff.ahi;  ds[3] = s0_item_ff.blo;
      xs[4] = s0_item_ff.ahi;  ds[4] = s0_item_ff.bhi;
      for (int k = 0; k < DIV_LANES; k++) begin
         prod_in[k]     = PROD_BITS'(xs[k]) * PROD_BITS'(ds[k]);
         xm             = xs[k][WORD_BITS-1] ? (~xs[k] + 1'b1) : xs[k];
         dm             = ds[k][WORD_BITS-1] ? (~ds[k] + 1'b1) : ds[k];
         lane_in[k].rem = '0;
         lane_in[k].sh  = NUM_BITS'(xm) << FRAC_BITS;
         lane_in[k].dvs = dm;
         lane_in[k].neg = xs[k][WORD_BITS-1] ^ ds[k][WORD_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff <= s0_item_ff;
         s1_prod_ff <= prod_in;
         s1_lane_ff <= lane_in;
      end
   end

   // results of every mode but divide, unsaturated
   always_comb begin
      wide_type pf [DIV_LANES];
      wide_type pc [DIV_LANES];
      for (int k = 0; k < DIV_LANES; k++) begin
         pf[k] = WIDE_BITS'(s1_prod_ff[k] >>> FRAC_BITS);
         pc[k] = WIDE_BITS'((s1_prod_ff[k] + FRAC_MASK) >>> FRAC_BITS);
      end
      pre_in = '0;
      case (s1_item_ff.op)
         OP_ADD: begin
            pre_in.c  = WIDE_BITS'(s1_item_ff.ac)  + WIDE_BITS'(s1_item_ff.bc);
            pre_in.lo = WIDE_BITS'(s1_item_ff.alo) + WIDE_BITS'(s1_item_ff.blo);
            pre_in.hi = WIDE_BITS'(s1_item_ff.ahi) + WIDE_BITS'(s1_item_ff.bhi);
         end
         OP_SUB: begin
            pre_in.c  = WIDE_BITS'(s1_item_ff.ac)  - WIDE_BITS'(s1_item_ff.bc);
            pre_in.lo = WIDE_BITS'(s1_item_ff.alo) - WIDE_BITS'(s1_item_ff.bhi);
            pre_in.hi = WIDE_BITS'(s1_item_ff.ahi) - WIDE_BITS'(s1_item_ff.blo);
         end
         OP_MUL: begin
            pre_in.c  = pf[0];
            pre_in.lo = wmin(wmin(pf[1], pf[2]), wmin(pf[3], pf[4]));
            pre_in.hi = wmax(wmax(pc[1], pc[2]), wmax(pc[3], pc[4]));
         end
         OP_MID: begin
            pre_in.c  = (WIDE_BITS'(s1_item_ff.alo) + WIDE_BITS'(s1_item_ff.ahi)) >>> 1;
            pre_in.lo = WIDE_BITS'(s1_item_ff.alo);
            pre_in.hi = WIDE_BITS'(s1_item_ff.ahi);
         end
         default: pre_in = '0;
      endcase
   end

   // divider pipe: one quotient bit per stage in each lane
   for (genvar j = 0; j < NUM_BITS; j++) begin : g_div
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               d_valid_ff[j] <= 1'b0;
            end else if (en) begin
               d_valid_ff[j] <= s1_valid_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               d_op_ff[j]   <= s1_item_ff.op;
               d_zdiv_ff[j] <= s1_item_ff.zdiv;
               d_pre_ff[j]  <= pre_in;
               for (int k = 0; k < DIV_LANES; k++) begin
                  d_lane_ff[j][k] <= div_step(s1_lane_ff[k]);
               end
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               d_valid_ff[j] <= 1'b0;
            end else if (en) begin
               d_valid_ff[j] <= d_valid_ff[j-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               d_op_ff[j]   <= d_op_ff[j-1];
               d_zdiv_ff[j] <= d_zdiv_ff[j-1];
               d_pre_ff[j]  <= d_pre_ff[j-1];
               for (int k = 0; k < DIV_LANES; k++) begin
                  d_lane_ff[j][k] <= div_step(d_lane_ff[j-1][k]);
               end
            end
         end
      end
   end

   // quotient signs and outward rounding
   always_comb begin
      wide_type qs;
      logic     nz;
      for (int k = 0; k < DIV_LANES; k++) begin
         qs = $signed(WIDE_BITS'(d_lane_ff[NUM_BITS-1][k].sh));
         nz = (d_lane_ff[NUM_BITS-1][k].rem != '0);
         if (d_lane_ff[NUM_BITS-1][k].neg) begin
            fl[k] = -qs - WIDE_BITS'(nz);
            cl[k] = -qs;
         end else begin
            fl[k] = qs;
            cl[k] = qs + WIDE_BITS'(nz);
         end
      end
      if ((d_op_ff[NUM_BITS-1] == OP_DIV) && !d_zdiv_ff[NUM_BITS-1]) begin
         e_res_in.c  = fl[0];
         e_res_in.lo = wmin(wmin(fl[1], fl[2]), wmin(fl[3], fl[4]));
         e_res_in.hi = wmax(wmax(cl[1], cl[2]), wmax(cl[3], cl[4]));
      end else begin
         e_res_in = d_pre_ff[NUM_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= d_valid_ff[NUM_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_res_ff  <= e_res_in;
         e_zdiv_ff <= (d_op_ff[NUM_BITS-1] == OP_DIV) && d_zdiv_ff[NUM_BITS-1];
      end
   end

   // saturation and status
   always_comb begin
      fin.c  = saturate(e_res_ff.c);
      fin.lo = saturate(e_res_ff.lo);
      fin.hi = saturate(e_res_ff.hi);
      if (e_zdiv_ff) begin
         fin.status = STATUS_ZDIV;
      end else if (overflows(e_res_ff.c) || overflows(e_res_ff.lo)
                   || overflows(e_res_ff.hi)) begin
         fin.status = STATUS_SAT;
      end else begin
         fin.status = STATUS_OK;
      end
   end

   // two-beat output queue
   assign oq_full   = (oq_count_ff == 2'd2);
   assign rsp_empty = (oq_count_ff == 2'd0);
   assign oq_push   = en && e_valid_ff;
   assign oq_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      oq_count_in = oq_count_ff;
      if (oq_push && !oq_pop) begin
         oq_count_in = oq_count_ff + 1'b1;
      end else if (oq_pop && !oq_push) begin
         oq_count_in = oq_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= 1'b0;
         oq_rd_ff    <= 1'b0;
         oq_count_ff <= '0;
      end else begin
         oq_wr_ff    <= oq_wr_ff ^ oq_push;
         oq_rd_ff    <= oq_rd_ff ^ oq_pop;
         oq_count_ff <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= fin;
      end
   end

   assign rsp_res_center = oq_ff[oq_rd_ff].c;
   assign rsp_res_low    = oq_ff[oq_rd_ff].lo;
   assign rsp_res_high   = oq_ff[oq_rd_ff].hi;
   assign rsp_status     = oq_ff[oq_rd_ff].status;

endmodule

// File: hdl/interval_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// interval_arithmetic_unit_core: interval add, subtract, multiply, divide
// and midpoint in signed Q16.16 with outward rounding and saturation.
// ----------------------------------------------------------------------------
// Use:
//  Request side is a queue write port: drive req_* and raise req_push; the
//  beat is taken on an edge where req_full is low. Result side is a queue
//  read port: while rsp_empty is low the oldest result sits on rsp_*, and
//  raising rsp_pop takes it. Every request gives exactly one result, in
//  order.
//  Every mode passes through the 48-stage divider pipe (one quotient bit
//  per stage) on its way to the result side.
//  Throughput: one beat per cycle, sustained, while results are popped.
//  If the reader stalls, the datapath freezes once the two-beat output
//  queue fills; the four-beat request queue then fills and req_full rises.
//  Reset (synchronous, active high) empties both queues and the pipe.
// ----------------------------------------------------------------------------
module interval_arithmetic_unit_core
   import iau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_mode,
   input  word_type   req_a_center,
   input  word_type   req_a_low,
   input  word_type   req_a_high,
   input  word_type   req_b_center,
   input  word_type   req_b_low,
   input  word_type   req_b_high,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output word_type   rsp_res_center,
   output word_type   rsp_res_low,
   output word_type   rsp_res_high,
   output logic [1:0] rsp_status
);

   item_type front_item;
   item_type q_item;
   logic     q_empty;
   logic     q_pop;

   iau_front u_front (
      .mode     (req_mode),
      .a_center (req_a_center),
      .a_low    (req_a_low),
      .a_high   (req_a_high),
      .b_center (req_b_center),
      .b_low    (req_b_low),
      .b_high   (req_b_high),
      .item     (front_item)
   );

   iau_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_item (front_item),
      .full    (req_full),
      .pop     (q_pop),
      .rd_item (q_item),
      .empty   (q_empty)
   );

   iau_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_res_center (rsp_res_center),
      .rsp_res_low    (rsp_res_low),
      .rsp_res_high   (rsp_res_high),
      .rsp_status     (rsp_status)
   );

endmodule

// File: bench/interval_arithmetic_unit_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_arithmetic_unit_core_tb: self-checking bench of the interval unit
// A short table of directed beats covers the extremes, every mode, swapped
// bounds, zero divisors and saturation. A random run follows. Every result
// beat is checked against a typed-in answer or an in-bench interval calculator.
// ----------------------------------------------------------------------------
module interval_arithmetic_unit_core_tb;
   import iau_pkg::*;

   localparam int N_RANDOM   = 400;
   localparam int BURST_LEN  = 80;
   localparam int DRAIN_WAIT = 80;
   localparam int STALL_LEN  = 200;
   localparam logic [2:0] MODE_BAD = 3'd7;

   typedef struct {
      logic [2:0] mode;
      word_type   ac, alo, ahi, bc, blo, bhi;
   } beat_type;

   typedef struct {
      word_type   c, lo, hi;
      logic [1:0] status;
   } interval_type;

   // one directed row: stimulus, and a typed-in answer where it is obvious
   typedef struct {
      beat_type     stim;
      logic         typed;
      interval_type ans;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [2:0] req_mode = '0;
   word_type   req_a_center = '0, req_a_low = '0, req_a_high = '0;
   word_type   req_b_center = '0, req_b_low = '0, req_b_high = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   word_type   rsp_res_center, rsp_res_low, rsp_res_high;
   logic [1:0] rsp_status;

   interval_type pending_results[$];
   int  fails = 0;
   bit  feed_done = 1'b0;
   bit  hold_reader = 1'b0;

   always #5 clock = ~clock;

   interval_arithmetic_unit_core dut (.*);

   // ---------------------------------------------------------------- calculator
   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if (n % d != 0 && ((n < 0) != (d < 0))) q--;
      return q;
   endfunction

   function automatic longint ceil_div(longint n, longint d);
      longint q;
      q = n / d;
      if (n % d != 0 && ((n < 0) == (d < 0))) q++;
      return q;
   endfunction

   function automatic longint clip(longint v, ref bit hit);
      if (v > 64'sd2147483647) begin hit = 1; return 64'sd2147483647; end
      if (v < -64'sd2147483648) begin hit = 1; return -64'sd2147483648; end
      return v;
   endfunction

   function automatic interval_type interval_calc(beat_type b);
      interval_type r;
      longint ac, alo, ahi, bc, blo, bhi, t, c, lo, hi, p, pl, ph;
      longint av[2], bv[2];
      longint one;
      bit hit;
      one = 64'sd65536;
      ac = b.ac; alo = b.alo; ahi = b.ahi;
      bc = b.bc; blo = b.blo; bhi = b.bhi;
      c = 0; lo = 0; hi = 0; hit = 0;
      r.status = STATUS_OK;
      if (alo > ahi) begin t = alo; alo = ahi; ahi = t; end
      if (blo > bhi) begin t = blo; blo = bhi; bhi = t; end
      av[0] = alo; av[1] = ahi; bv[0] = blo; bv[1] = bhi;
      case (b.mode)
         MODE_ADD: begin c = ac + bc; lo = alo + blo; hi = ahi + bhi; end
         MODE_SUB: begin c = ac - bc; lo = alo - bhi; hi = ahi - blo; end
         MODE_MUL: begin
            c = floor_div(ac * bc, one);
            for (int i = 0; i < 4; i++) begin
               p = av[i >> 1] * bv[i & 1];
               pl = floor_div(p, one); ph = ceil_div(p, one);
               if (i == 0 || pl < lo) lo = pl;
               if (i == 0 || ph > hi) hi = ph;
            end
         end
         MODE_DIV: begin
            if ((blo <= 0 && bhi >= 0) || bc == 0) begin
               r.status = STATUS_ZDIV;
            end else begin
               c = floor_div(ac * one, bc);
               for (int i = 0; i < 4; i++) begin
                  p = av[i >> 1] * one;
                  pl = floor_div(p, bv[i & 1]); ph = ceil_div(p, bv[i & 1]);
                  if (i == 0 || pl < lo) lo = pl;
                  if (i == 0 || ph > hi) hi = ph;
               end
            end
         end
         MODE_MID: begin c = floor_div(alo + ahi, 2); lo = alo; hi = ahi; end
         default: ;
      endcase
      c = clip(c, hit); lo = clip(lo, hit); hi = clip(hi, hit);
      if (r.status == STATUS_OK && hit) r.status = STATUS_SAT;
      r.c = word_type'(c); r.lo = word_type'(lo); r.hi = word_type'(hi);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic word_type any_word();
      case ($urandom_range(0, 5))
         0: return word_type'($urandom_range(0, 3) == 0 ? 32'h7fffffff : 32'h80000000);
         1, 2: return word_type'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
         default: return word_type'($urandom());
      endcase
   endfunction

   function automatic beat_type random_beat();
      beat_type b;
      b.mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
      b.ac = any_word(); b.alo = any_word(); b.ahi = any_word();
      b.bc = any_word(); b.blo = any_word(); b.bhi = any_word();
      // mostly ordered, well-formed intervals around the centre
      if ($urandom_range(0, 3) != 0) begin
         b.alo = b.ac - word_type'($urandom_range(0, 32'h0003ffff));
         b.ahi = b.ac + word_type'($urandom_range(0, 32'h0003ffff));
         if (b.alo > b.ac) b.alo = b.ac;
         if (b.ahi < b.ac) b.ahi = b.ac;
      end
      if ($urandom_range(0, 3) != 0) begin
         b.blo = b.bc - word_type'($urandom_range(0, 32'h0000ffff));
         b.bhi = b.bc + word_type'($urandom_range(0, 32'h0000ffff));
         if (b.blo > b.bc) b.blo = b.bc;
         if (b.bhi < b.bc) b.bhi = b.bc;
      end
      if ($urandom_range(0, 9) == 0) begin b.blo = b.bc; b.bhi = b.bc; end
      return b;
   endfunction

   function automatic row_type mk(logic [2:0] m, word_type ac, word_type alo, word_type ahi,
                                  word_type bc, word_type blo, word_type bhi);
      row_type r;
      r.stim.mode = m; r.stim.ac = ac; r.stim.alo = alo; r.stim.ahi = ahi;
      r.stim.bc = bc; r.stim.blo = blo; r.stim.bhi = bhi;
      r.typed = 1'b0;
      r.ans = '{c: '0, lo: '0, hi: '0, status: STATUS_OK};
      return r;
   endfunction

   function automatic row_type known(row_type r, word_type c, word_type lo, word_type hi,
                                     logic [1:0] st);
      r.typed = 1'b1;
      r.ans = '{c: c, lo: lo, hi: hi, status: st};
      return r;
   endfunction

   // push stays high after the beat; the caller drops it before any gap
   task automatic send_beat(beat_type b, interval_type exp_res);
      req_push     <= 1'b1;
      req_mode     <= b.mode;
      req_a_center <= b.ac;  req_a_low <= b.alo;  req_a_high <= b.ahi;
      req_b_center <= b.bc;  req_b_low <= b.blo;  req_b_high <= b.bhi;
      do @(posedge clock); while (req_full);
      pending_results.push_back(exp_res);
   endtask

   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- sender
   initial begin
      row_type    rows[$];
      beat_type   b;
      word_type   max_w, min_w, one_w;
      int         gap;
      max_w = 32'sh7fffffff; min_w = 32'sh80000000; one_w = 32'sh00010000;

      rows.push_back(known(mk(MODE_ADD, 0, 0, 0, 0, 0, 0), 0, 0, 0, STATUS_OK));
      rows.push_back(known(mk(MODE_ADD, max_w, max_w, max_w, one_w, one_w, one_w),
                           max_w, max_w, max_w, STATUS_SAT));
      rows.push_back(known(mk(MODE_SUB, min_w, min_w, min_w, one_w, one_w, one_w),
                           min_w, min_w, min_w, STATUS_SAT));
      rows.push_back(known(mk(MODE_DIV, one_w, one_w, one_w, 0, 0, 0), 0, 0, 0, STATUS_ZDIV));
      rows.push_back(known(mk(MODE_DIV, one_w, one_w, one_w, one_w, -one_w, one_w),
                           0, 0, 0, STATUS_ZDIV));
      rows.push_back(known(mk(MODE_DIV, one_w, one_w, one_w, 0, one_w, 2*one_w),
                           0, 0, 0, STATUS_ZDIV));
      rows.push_back(known(mk(MODE_MID, 0, 2*one_w, 0, 0, 0, 0), one_w, 0, 2*one_w,
                           STATUS_OK));
      rows.push_back(known(mk(MODE_BAD, max_w, min_w, max_w, max_w, min_w, max_w),
                           0, 0, 0, STATUS_OK));
      rows.push_back(known(mk(3'd5, 1, 1, 1, 1, 1, 1), 0, 0, 0, STATUS_OK));
      rows.push_back(known(mk(3'd6, -1, -1, -1, -1, -1, -1), 0, 0, 0, STATUS_OK));
      rows.push_back(mk(MODE_ADD, one_w, -one_w, 3*one_w, -one_w, 2*one_w, -2*one_w));
      rows.push_back(mk(MODE_SUB, max_w, min_w, max_w, min_w, max_w, min_w));
      rows.push_back(mk(MODE_MUL, 2*one_w, -one_w, 3*one_w, -3*one_w, -5*one_w, 2*one_w));
      rows.push_back(mk(MODE_MUL, max_w, max_w, max_w, max_w, max_w, max_w));
      rows.push_back(mk(MODE_MUL, min_w, min_w, min_w, min_w, min_w, min_w));
      rows.push_back(mk(MODE_MUL, -1, -3, 5, 7, 7, -7));
      rows.push_back(mk(MODE_DIV, one_w, -one_w, 3*one_w, 3*one_w, 2*one_w, 5*one_w));
      rows.push_back(mk(MODE_DIV, -7*one_w, -9*one_w, 5, -3*one_w, -one_w, -7*one_w));
      rows.push_back(mk(MODE_DIV, max_w, min_w, max_w, 1, 1, 1));
      rows.push_back(mk(MODE_DIV, min_w, min_w, max_w, -1, -1, -1));
      rows.push_back(mk(MODE_MID, 0, max_w, max_w, 0, 0, 0));
      rows.push_back(mk(MODE_MID, 0, min_w, min_w + 1, 0, 0, 0));
      rows.push_back(mk(MODE_MID, 0, max_w, min_w, 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (rows[i])
         send_beat(rows[i].stim, rows[i].typed ? rows[i].ans : interval_calc(rows[i].stim));

      // burst with the reader held off: fills the queues and raises req_full
      hold_reader = 1'b1;
      for (int i = 0; i < BURST_LEN; i++) begin
         b = random_beat();
         send_beat(b, interval_calc(b));
      end
      req_push <= 1'b0;
      wait (hold_reader == 1'b0);

      // pause until everything is back
      wait (pending_results.size() == 0);

      for (int i = 0; i < N_RANDOM; i++) begin
         gap = (i % 100 < 30) ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            req_push <= 1'b0;
            idle_cycles(gap);
         end
         b = random_beat();
         send_beat(b, interval_calc(b));
      end
      req_push <= 1'b0;
      feed_done = 1'b1;
   end

   // ---------------------------------------------------------------- receiver
   initial begin
      interval_type want;
      int gap;
      rsp_pop <= 1'b0;
      wait (hold_reader == 1'b1);
      repeat (STALL_LEN) @(posedge clock);
      hold_reader = 1'b0;
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            idle_cycles(gap);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            fails++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_center !== want.c) begin
               $error("res_center expected %0d got %0d", want.c, rsp_res_center); fails++;
            end
            if (rsp_res_low !== want.lo) begin
               $error("res_low expected %0d got %0d", want.lo, rsp_res_low); fails++;
            end
            if (rsp_res_high !== want.hi) begin
               $error("res_high expected %0d got %0d", want.hi, rsp_res_high); fails++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_status); fails++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- end of run
   initial begin
      wait (feed_done && pending_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fails == 0 && pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
